// File: rtl/ltvm_pkg.sv
// Shared constants, codes and control types of the looping track and voice mixer.
`timescale 1ns / 1ps

package ltvm_pkg;

    localparam int TRACK_DEPTH    = 65536;
    localparam int EFFECT_DEPTH   = 16384;
    localparam int EFFECT_ENTRIES = 16;
    localparam int VOICES         = 4;

    localparam int TRACK_AW  = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int EFFECT_AW = (EFFECT_DEPTH > 1) ? $clog2(EFFECT_DEPTH) : 1;
    localparam int ENTRY_W   = (EFFECT_ENTRIES > 1) ? $clog2(EFFECT_ENTRIES) : 1;
    localparam int VOICE_W   = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam int TPOS_W = 17;
    localparam int VPOS_W = 15;
    localparam int CFG_DW = 17;
    localparam int CFG_IW = 2;

    localparam logic [2:0] KIND_TICK         = 3'd0;
    localparam logic [2:0] KIND_WR_TRACK     = 3'd1;
    localparam logic [2:0] KIND_WR_EFFECT    = 3'd2;
    localparam logic [2:0] KIND_DEF_EFFECT   = 3'd3;
    localparam logic [2:0] KIND_START_TRACK  = 3'd4;
    localparam logic [2:0] KIND_STOP         = 3'd5;
    localparam logic [2:0] KIND_PAUSE        = 3'd6;
    localparam logic [2:0] KIND_START_EFFECT = 3'd7;

    localparam logic [CFG_IW-1:0] CFG_TRACK_LENGTH = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_LOOP_START   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TRACK_COUNT  = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_EFFECT_COUNT = 2'd3;

    typedef struct packed {
        logic [13:0] offset;
        logic [14:0] length;
    } ltvm_fx_t;

    typedef struct packed {
        logic               apply;
        logic               trk;
        logic               mix;
        logic [VOICE_W-1:0] vsel;
        logic               fin;
        logic               out_load;
    } ltvm_cmd_t;

    typedef struct packed {
        logic out_free;
    } ltvm_sts_t;

endpackage

// File: rtl/ltvm_ctrl.sv
// Controller state machine sequencing item application and the per-tick mix.
`timescale 1ns / 1ps

module ltvm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          kind,
    output logic                in_stall,
    input  ltvm_pkg::ltvm_sts_t sts,
    output ltvm_pkg::ltvm_cmd_t cmd
);
    import ltvm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TRK  = 3'd1;
    localparam logic [2:0] S_MIX  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICES - 1);

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [VOICE_W-1:0] cnt_reg;
    logic [VOICE_W-1:0] cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.vsel     = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_TICK)
                    begin
                        state_next = S_TRK;
                    end
                    else
                    begin
                        cmd.apply = 1'b1;
                    end
                end
            end
            S_TRK:
            begin
                cmd.trk    = 1'b1;
                cnt_next   = '0;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix = 1'b1;
                if (cnt_reg == LAST_VOICE)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTH
    a_tick_starts_mix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && kind == KIND_TICK) |=> (state_reg == S_TRK))
        else $error("tick transaction did not start the mix");

    a_mix_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRK) |=> (state_reg == S_MIX && cnt_reg == '0))
        else $error("voice sweep did not start at the first voice");

    a_out_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && sts.out_free) |=> (state_reg == S_IDLE && !in_stall))
        else $error("result hand-off did not release the input channel");
`endif

endmodule

// File: rtl/ltvm_dp.sv
// Datapath: sample memories, effect table, track and voice state, mix accumulator, output register.
`timescale 1ns / 1ps

module ltvm_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ltvm_pkg::ltvm_cmd_t            cmd,
    output ltvm_pkg::ltvm_sts_t            sts,
    input  logic [2:0]                     kind,
    input  logic [15:0]                    address,
    input  logic signed [15:0]             value,
    input  logic [3:0]                     effect_index,
    input  logic [13:0]                    effect_offset,
    input  logic [14:0]                    effect_length,
    input  logic [1:0]                     voice,
    input  logic [7:0]                     track_index,
    input  logic                           cfg_wr,
    input  logic [ltvm_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [ltvm_pkg::CFG_DW-1:0]    cfg_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [15:0]             sample
);
    import ltvm_pkg::*;

    logic signed [15:0] track_mem [TRACK_DEPTH];
    logic signed [15:0] effect_mem [EFFECT_DEPTH];

    logic [16:0] track_length_reg;
    logic [15:0] loop_start_reg;
    logic [7:0]  track_count_reg;
    logic [4:0]  effect_count_reg;

    ltvm_fx_t fx_reg [EFFECT_ENTRIES];

    logic [TPOS_W-1:0] tpos_reg;
    logic              playing_reg;
    logic              paused_reg;

    logic [VPOS_W-1:0] vpos_reg [VOICES];
    logic [VPOS_W-1:0] vend_reg [VOICES];
    logic [VOICES-1:0] vact_reg;

    logic signed [15:0] trk_rd_reg;
    logic               trk_hit_reg;
    logic signed [15:0] eff_rd_reg;
    logic               eff_hit_reg;
    logic signed [15:0] acc_reg;
    logic               out_valid_reg;
    logic signed [15:0] sample_reg;

    logic do_wr_trk;
    logic do_wr_eff;
    logic do_def;
    logic do_start_trk;
    logic do_stop;
    logic do_pause;
    logic do_start_fx;

    logic [TPOS_W-1:0]  wrap_pos;
    logic [TPOS_W-1:0]  tpos_eff;
    logic [TPOS_W-1:0]  tpos_inc;
    logic [TPOS_W-1:0]  tpos_adv;
    logic               trk_on;
    logic [TRACK_AW-1:0]  trk_ra;
    logic [EFFECT_AW-1:0] eff_ra;

    ltvm_fx_t           fx_sel;
    logic [VPOS_W:0]    fx_sum;
    logic [VPOS_W-1:0]  fx_end;
    logic               fx_ok;
    logic [VOICE_W-1:0] vstart;
    logic [VPOS_W-1:0]  vpos_cur;
    logic [VPOS_W-1:0]  vpos_inc;
    logic               vact_cur;
    logic [16:0]        mix_sum;
    logic signed [15:0] mix_sat;

    always_comb
    begin
        do_wr_trk    = 1'b0;
        do_wr_eff    = 1'b0;
        do_def       = 1'b0;
        do_start_trk = 1'b0;
        do_stop      = 1'b0;
        do_pause     = 1'b0;
        do_start_fx  = 1'b0;
        if (cmd.apply)
        begin
            unique case (kind)
                KIND_WR_TRACK:     do_wr_trk    = (32'(address) < TRACK_DEPTH);
                KIND_WR_EFFECT:    do_wr_eff    = (32'(address) < EFFECT_DEPTH);
                KIND_DEF_EFFECT:   do_def       = (32'(effect_index) < EFFECT_ENTRIES);
                KIND_START_TRACK:  do_start_trk = (track_index < track_count_reg);
                KIND_STOP:         do_stop      = 1'b1;
                KIND_PAUSE:        do_pause     = 1'b1;
                KIND_START_EFFECT: do_start_fx  = fx_ok;
                default:           ;
            endcase
        end
    end

    // track position: wrap before and after the step
    always_comb
    begin
        wrap_pos = (TPOS_W'(loop_start_reg) < track_length_reg) ? TPOS_W'(loop_start_reg) : '0;
        tpos_eff = (tpos_reg >= track_length_reg) ? wrap_pos : tpos_reg;
        tpos_inc = tpos_eff + 1'b1;
        tpos_adv = (tpos_inc >= track_length_reg) ? wrap_pos : tpos_inc;
        trk_on   = playing_reg && !paused_reg && (track_length_reg != '0);
        trk_ra   = TRACK_AW'(tpos_eff);
    end

    // effect start: clamp end to memory
    always_comb
    begin
        fx_sel = fx_reg[ENTRY_W'(effect_index)];
        fx_sum = {1'b0, VPOS_W'(fx_sel.offset)} + {1'b0, fx_sel.length};
        fx_end = (32'(fx_sum) > EFFECT_DEPTH) ? VPOS_W'(EFFECT_DEPTH) : fx_sum[VPOS_W-1:0];
        fx_ok  = ({1'b0, effect_index} < effect_count_reg)
              && (32'(effect_index) < EFFECT_ENTRIES)
              && (32'(voice) < VOICES)
              && (fx_sel.length != '0)
              && (VPOS_W'(fx_sel.offset) < fx_end);
        vstart = VOICE_W'(voice);
    end

    always_comb
    begin
        vpos_cur = vpos_reg[cmd.vsel];
        vpos_inc = vpos_cur + 1'b1;
        vact_cur = vact_reg[cmd.vsel];
        eff_ra   = EFFECT_AW'(vpos_cur);
        mix_sum  = {acc_reg[15], acc_reg} + {eff_rd_reg[15], eff_rd_reg};
        if (mix_sum[16] != mix_sum[15])
        begin
            mix_sat = mix_sum[16] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            mix_sat = mix_sum[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr_trk)
        begin
            track_mem[TRACK_AW'(address)] <= value;
        end
        trk_rd_reg <= track_mem[trk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (do_wr_eff)
        begin
            effect_mem[EFFECT_AW'(address)] <= value;
        end
        eff_rd_reg <= effect_mem[eff_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_length_reg <= '0;
            loop_start_reg   <= '0;
            track_count_reg  <= '0;
            effect_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_TRACK_LENGTH: track_length_reg <= cfg_data;
                CFG_LOOP_START:   loop_start_reg   <= cfg_data[15:0];
                CFG_TRACK_COUNT:  track_count_reg  <= cfg_data[7:0];
                CFG_EFFECT_COUNT: effect_count_reg <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < EFFECT_ENTRIES; i++)
            begin
                fx_reg[i] <= '0;
            end
        end
        else if (do_def)
        begin
            fx_reg[ENTRY_W'(effect_index)] <= '{offset: effect_offset, length: effect_length};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpos_reg    <= '0;
            playing_reg <= 1'b0;
            paused_reg  <= 1'b0;
            trk_hit_reg <= 1'b0;
        end
        else
        begin
            if (do_start_trk)
            begin
                tpos_reg    <= '0;
                playing_reg <= 1'b1;
                paused_reg  <= 1'b0;
            end
            if (do_stop)
            begin
                playing_reg <= 1'b0;
            end
            if (do_pause)
            begin
                paused_reg <= !paused_reg;
            end
            if (cmd.trk)
            begin
                trk_hit_reg <= trk_on && (32'(tpos_eff) < TRACK_DEPTH);
                if (trk_on)
                begin
                    tpos_reg <= tpos_adv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                vpos_reg[i] <= '0;
                vend_reg[i] <= '0;
            end
            vact_reg    <= '0;
            eff_hit_reg <= 1'b0;
        end
        else
        begin
            if (do_start_fx)
            begin
                vpos_reg[vstart] <= VPOS_W'(fx_sel.offset);
                vend_reg[vstart] <= fx_end;
                vact_reg[vstart] <= 1'b1;
            end
            if (cmd.mix)
            begin
                eff_hit_reg <= vact_cur && (32'(vpos_cur) < EFFECT_DEPTH);
                if (vact_cur)
                begin
                    vpos_reg[cmd.vsel] <= vpos_inc;
                    if (vpos_inc >= vend_reg[cmd.vsel])
                    begin
                        vact_reg[cmd.vsel] <= 1'b0;
                    end
                end
            end
        end
    end

    // load track sample on the first voice slot, add each voice in the cycle after its read
    always_ff @(posedge clk)
    begin
        if (cmd.mix && cmd.vsel == '0)
        begin
            acc_reg <= trk_hit_reg ? trk_rd_reg : '0;
        end
        else if ((cmd.mix || cmd.fin) && eff_hit_reg)
        begin
            acc_reg <= mix_sat;
        end
        if (cmd.out_load)
        begin
            sample_reg <= acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while a transaction waits");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("output valid rose without a load");

    for (genvar g = 0; g < VOICES; g++)
    begin : g_vchk
        a_voice_in_range: assert property (@(posedge clk) disable iff (!rst_n)
            vact_reg[g] |-> (vpos_reg[g] < vend_reg[g]))
            else $error("active voice at or beyond its end");
    end
`endif

endmodule

// File: rtl/looping_track_and_voice_mixer.sv
// Top level of the looping track and voice mixer.
// Non-tick transaction: applied at its accept edge, next item taken the following cycle.
// Tick: result registered after the track read and the sequential sweep of one effect memory
//   read per voice, once the output register is free to load.
// During a tick the input is stalled until its result is loaded into the output register.
// Reset: asynchronous; clears control, config, effect table and voices; memories keep contents.
`timescale 1ns / 1ps

module looping_track_and_voice_mixer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  kind,
    input  logic [15:0]                 address,
    input  logic signed [15:0]          value,
    input  logic [3:0]                  effect_index,
    input  logic [13:0]                 effect_offset,
    input  logic [14:0]                 effect_length,
    input  logic [1:0]                  voice,
    input  logic [7:0]                  track_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [15:0]          sample,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ltvm_pkg::CFG_IW-1:0] cfg_index,
    input  logic [ltvm_pkg::CFG_DW-1:0] cfg_data
);
    import ltvm_pkg::*;

    ltvm_cmd_t cmd;
    ltvm_sts_t sts;

    assign cfg_ready = 1'b1;

    ltvm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ltvm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .address       (address),
        .value         (value),
        .effect_index  (effect_index),
        .effect_offset (effect_offset),
        .effect_length (effect_length),
        .voice         (voice),
        .track_index   (track_index),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample)
    );

endmodule

// File: sim/mix_checker.sv
// Mixer checker: follows every transaction, predicts each output sample and compares.
`timescale 1ns / 1ps

module mix_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [2:0]                    kind,
    input  logic [15:0]                   address,
    input  logic signed [15:0]            value,
    input  logic [3:0]                    effect_index,
    input  logic [13:0]                   effect_offset,
    input  logic [14:0]                   effect_length,
    input  logic [1:0]                    voice,
    input  logic [7:0]                    track_index,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [15:0]            sample,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ltvm_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [ltvm_pkg::CFG_DW-1:0]   cfg_data,
    output int                            outstanding,
    output int                            fail_count
);
    import ltvm_pkg::*;

    logic signed [15:0] track_mem [TRACK_DEPTH];
    logic signed [15:0] effect_mem [EFFECT_DEPTH];
    ltvm_fx_t           fx_table [EFFECT_ENTRIES];
    logic [TPOS_W-1:0]  track_pos;
    logic               playing;
    logic               paused;
    logic [VPOS_W-1:0]  voice_pos [VOICES];
    logic [VPOS_W-1:0]  voice_stop [VOICES];
    logic               voice_on [VOICES];
    logic [16:0]        trk_length;
    logic [15:0]        loop_at;
    logic [7:0]         tracks_avail;
    logic [4:0]         effects_avail;
    logic signed [15:0] due_samples [$];
    int                 mismatches = 0;

    assign fail_count = mismatches;

    task report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 30)
            $display("[%0t] mixer mismatch: %s", $time, what);
    endtask

    function automatic int clip16(input int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function logic signed [15:0] next_mixed_sample();
        int                acc;
        logic [TPOS_W-1:0] wrap_to;
        acc = 0;
        if (playing && !paused && trk_length != 0)
        begin
            wrap_to = (loop_at < trk_length) ? TPOS_W'(loop_at) : '0;
            if (track_pos >= trk_length)
                track_pos = wrap_to;
            acc = int'(track_mem[track_pos[TRACK_AW-1:0]]);
            track_pos = track_pos + 1'b1;
            if (track_pos >= trk_length)
                track_pos = wrap_to;
        end
        for (int v = 0; v < VOICES; v++)
        begin
            if (voice_on[v])
            begin
                acc = clip16(acc + int'(effect_mem[voice_pos[v][EFFECT_AW-1:0]]));
                voice_pos[v] = voice_pos[v] + 1'b1;
                if (voice_pos[v] >= voice_stop[v])
                    voice_on[v] = 1'b0;
            end
        end
        return 16'(acc);
    endfunction

    task take_item();
        ltvm_fx_t fx;
        int       fx_end;
        fx = fx_table[effect_index];
        fx_end = int'(fx.offset) + int'(fx.length);
        if (fx_end > EFFECT_DEPTH)
            fx_end = EFFECT_DEPTH;
        case (kind)
            KIND_WR_TRACK:
                track_mem[address] = value;
            KIND_WR_EFFECT:
                if (int'(address) < EFFECT_DEPTH)
                    effect_mem[address[EFFECT_AW-1:0]] = value;
            KIND_DEF_EFFECT:
                if (int'(effect_index) < EFFECT_ENTRIES)
                    fx_table[effect_index] = {effect_offset, effect_length};
            KIND_START_TRACK:
                if (track_index < tracks_avail)
                begin
                    track_pos = '0;
                    playing = 1'b1;
                    paused = 1'b0;
                end
            KIND_STOP:
                playing = 1'b0;
            KIND_PAUSE:
                paused = !paused;
            KIND_START_EFFECT:
                if (effect_index < effects_avail && int'(effect_index) < EFFECT_ENTRIES
                    && int'(voice) < VOICES && fx.length != 0 && int'(fx.offset) < fx_end)
                begin
                    voice_pos[voice] = VPOS_W'(fx.offset);
                    voice_stop[voice] = VPOS_W'(fx_end);
                    voice_on[voice] = 1'b1;
                end
            default:
                due_samples.push_back(next_mixed_sample());
        endcase
    endtask

    task check_sample();
        logic signed [15:0] want;
        if (due_samples.size() == 0)
            report_mismatch($sformatf("sample %0d with nothing expected", sample));
        else
        begin
            want = due_samples.pop_front();
            if (sample !== want)
                report_mismatch($sformatf("sample %0d, expected %0d", sample, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < EFFECT_ENTRIES; e++)
                fx_table[e] = '0;
            for (int v = 0; v < VOICES; v++)
            begin
                voice_pos[v] = '0;
                voice_stop[v] = '0;
                voice_on[v] = 1'b0;
            end
            track_pos = '0;
            playing = 1'b0;
            paused = 1'b0;
            trk_length = '0;
            loop_at = '0;
            tracks_avail = '0;
            effects_avail = '0;
            due_samples.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_sample();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TRACK_LENGTH: trk_length = cfg_data[16:0];
                    CFG_LOOP_START:   loop_at = cfg_data[15:0];
                    CFG_TRACK_COUNT:  tracks_avail = cfg_data[7:0];
                    CFG_EFFECT_COUNT: effects_avail = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                take_item();
            outstanding <= due_samples.size();
        end
    end

endmodule

// File: sim/testbench.sv
// Mixer testbench top: clock, reset, stimulus, receiver stalls and the final verdict.
`timescale 1ns / 1ps

module testbench;
    import ltvm_pkg::*;

    typedef struct {
        logic [2:0]         kind;
        logic [15:0]        address;
        logic signed [15:0] value;
        logic [3:0]         effect_index;
        logic [13:0]        effect_offset;
        logic [14:0]        effect_length;
        logic [1:0]         voice;
        logic [7:0]         track_index;
    } mix_item_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [2:0]               kind = '0;
    logic [15:0]              address = '0;
    logic signed [15:0]       value = '0;
    logic [3:0]               effect_index = '0;
    logic [13:0]              effect_offset = '0;
    logic [14:0]              effect_length = '0;
    logic [1:0]               voice = '0;
    logic [7:0]               track_index = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [15:0]       sample;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IW-1:0]        cfg_index = '0;
    logic [CFG_DW-1:0]        cfg_data = '0;
    int                       outstanding;
    int                       fail_count;

    int                       snd_idle = 7;
    int                       rcv_idle = 85;
    int                       hold_ask = 0;
    int                       hold_seen = 0;
    int                       hold_left = 0;
    logic [7:0]               tcount_set = '0;

    looping_track_and_voice_mixer DUT (.*);

    mix_checker mix_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_ask)
        begin
            hold_seen <= hold_ask;
            hold_left <= 200;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end

    function automatic mix_item_t mk(input logic [2:0] k, input int a, input int v,
                                     input int ei, input int eo, input int el,
                                     input int vc, input int ti);
        mix_item_t it;
        it.kind = k;
        it.address = 16'(a);
        it.value = 16'(v);
        it.effect_index = 4'(ei);
        it.effect_offset = 14'(eo);
        it.effect_length = 15'(el);
        it.voice = 2'(vc);
        it.track_index = 8'(ti);
        return it;
    endfunction

    // keep every effect entry inside the preloaded regions of effect memory
    function automatic mix_item_t random_item();
        mix_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            it.kind = KIND_TICK;
        else if (pick < 50)
            it.kind = KIND_WR_TRACK;
        else if (pick < 58)
            it.kind = KIND_WR_EFFECT;
        else if (pick < 66)
            it.kind = KIND_DEF_EFFECT;
        else if (pick < 73)
            it.kind = KIND_START_TRACK;
        else if (pick < 78)
            it.kind = KIND_STOP;
        else if (pick < 84)
            it.kind = KIND_PAUSE;
        else
            it.kind = KIND_START_EFFECT;
        it.address = 16'($urandom);
        if (it.kind == KIND_WR_EFFECT && $urandom_range(0, 1) == 1)
            it.address = 16'($urandom_range(0, EFFECT_DEPTH - 1));
        it.value = 16'($urandom);
        it.effect_index = 4'($urandom);
        it.effect_offset = 14'($urandom);
        it.effect_length = 15'($urandom_range(0, 16384));
        if (it.kind == KIND_DEF_EFFECT)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                it.effect_offset = 14'($urandom_range(0, 63));
                it.effect_length = 15'($urandom_range(0, 64));
            end
            else
                it.effect_offset = 14'($urandom_range(EFFECT_DEPTH - 128, EFFECT_DEPTH - 1));
        end
        it.voice = 2'($urandom);
        it.track_index = 8'($urandom);
        if (it.kind == KIND_START_TRACK && tcount_set != 0 && $urandom_range(0, 1) == 1)
            it.track_index = 8'($urandom_range(0, tcount_set - 1));
        return it;
    endfunction

    task automatic drive_item(input mix_item_t it);
        if (snd_idle != 0 && $urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= it.kind;
        address <= it.address;
        value <= it.value;
        effect_index <= it.effect_index;
        effect_offset <= it.effect_offset;
        effect_length <= it.effect_length;
        voice <= it.voice;
        track_index <= it.track_index;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DW'(data);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // hold the input until every sample is out and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic configure(input int len, input int loop, input int tcount,
                             input int ecount);
        settle();
        write_reg(CFG_TRACK_LENGTH, len);
        write_reg(CFG_LOOP_START, loop);
        write_reg(CFG_TRACK_COUNT, tcount);
        write_reg(CFG_EFFECT_COUNT, ecount);
        cfg_valid <= 1'b0;
        tcount_set = 8'(tcount);
    endtask

    task automatic run_phase(input int len, input int loop, input int tcount,
                             input int ecount, input int count, input bit hold);
        configure(len, loop, tcount, ecount);
        for (int n = 0; n < count; n++)
        begin
            if (hold && n == count / 4)
                hold_ask <= hold_ask + 1;
            drive_item(random_item());
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int a = 0; a < 128; a++)
        begin
            drive_item(mk(KIND_WR_TRACK, a, int'($urandom), 0, 0, 0, 0, 0));
            drive_item(mk(KIND_WR_EFFECT, a, int'($urandom), 0, 0, 0, 0, 0));
            drive_item(mk(KIND_WR_EFFECT, EFFECT_DEPTH - 128 + a, int'($urandom),
                          0, 0, 0, 0, 0));
        end

        configure(16, 4, 255, 16);
        drive_item(mk(KIND_WR_TRACK, 65535, -32768, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_WR_EFFECT, 65535, 32767, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_WR_TRACK, 0, 32767, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_WR_EFFECT, 0, 32767, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_WR_EFFECT, 1, -32768, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_WR_EFFECT, 2, -32768, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_DEF_EFFECT, 0, 0, 0, 0, 4, 0, 0));
        drive_item(mk(KIND_DEF_EFFECT, 0, 0, 15, 16383, 16384, 0, 0));
        drive_item(mk(KIND_DEF_EFFECT, 0, 0, 1, 16256, 0, 0, 0));
        drive_item(mk(KIND_START_TRACK, 0, 0, 0, 0, 0, 0, 255));
        drive_item(mk(KIND_START_TRACK, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_START_EFFECT, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_START_EFFECT, 0, 0, 0, 0, 0, 1, 0));
        drive_item(mk(KIND_START_EFFECT, 0, 0, 1, 0, 0, 2, 0));
        drive_item(mk(KIND_START_EFFECT, 0, 0, 15, 0, 0, 3, 0));
        drive_item(mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_START_EFFECT, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_PAUSE, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_PAUSE, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_STOP, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_PAUSE, 0, 0, 0, 0, 0, 0, 0));
        drive_item(mk(KIND_START_TRACK, 0, 0, 0, 0, 0, 0, 254));
        drive_item(mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));

        run_phase(64, 10, 4, 16, 110, 1'b0);
        run_phase(65536, 65535, 255, 8, 40, 1'b0);

        snd_idle = 85;
        rcv_idle <= 7;
        run_phase(0, 0, 0, 0, 60, 1'b0);
        run_phase(2, 65535, 1, 16, 110, 1'b0);

        snd_idle = 0;
        rcv_idle <= 0;
        run_phase(40, 38, 128, 12, 170, 1'b1);
        run_phase(62, 0, 200, 16, 150, 1'b1);

        settle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
